// ===== sv/pptc_pkg.sv =====
// ----------------------------------------------------------------------------
// pptc_pkg
// Shared types and codes for the push/pop trace classifier.
// ----------------------------------------------------------------------------
`default_nettype none
package pptc_pkg;

  localparam int unsigned VerdictBits = 3;

  typedef enum logic [VerdictBits-1:0] {
    VERDICT_IMPOSSIBLE = 3'd0,
    VERDICT_STACK      = 3'd1,
    VERDICT_QUEUE      = 3'd2,
    VERDICT_PRIORITY   = 3'd3,
    VERDICT_NOT_SURE   = 3'd4
  } verdict_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINEAR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_DN_RD_LAST,
    ST_DN_RD_L,
    ST_DN_RD_R,
    ST_DN_CMP,
    ST_WRITE,
    ST_DONE
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the input beat
    logic linear_op;  // stack/queue operation and heap head check
    logic up_start;   // heap push: set up sift-up
    logic up_rd;      // read parent
    logic up_step;    // compare parent, move or stop
    logic dn_start;   // heap pop: read last entry
    logic dn_rd_l;
    logic dn_rd_r;
    logic dn_step;
    logic hole_write; // write held value into the hole
    logic finish;     // verdict/clear on last
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic heap_push;   // heap takes a push
    logic heap_pop;    // heap pops with entries left to sift
    logic up_done;     // hole at root
    logic up_stop;     // parent not smaller
    logic dn_no_child; // no left child
    logic dn_has_r;    // right child exists
    logic dn_stop;     // larger child not above moved value
    logic last;
  } status_t;

endpackage
`default_nettype wire

// ===== sv/push_pop_trace_classifier.sv =====
// ----------------------------------------------------------------------------
// push_pop_trace_classifier
// Checks a push/pop trace against a stack, a queue and a max-heap.
// ----------------------------------------------------------------------------
// Sequence: IDLE loads a beat, LINEAR does the stack/queue work, DONE closes it;
// a heap push adds an UP_RD/UP_CMP loop per level, a pop a DN_RD loop, then WRITE.
// One beat in flight at a time; the sift loop over the heap memory sets rate.
// Verdict goes to a one-entry output register, so the next beat is taken
// while it waits. rst (synchronous) clears all counts and failure flags.
`default_nettype none
module push_pop_trace_classifier #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire         clk,
  input  wire         rst,
  input  wire         s_tvalid,
  output logic        s_tready,
  input  wire  [23:0] s_tdata,   // [0] cmd, [16:1] value, zero pad
  input  wire         s_tlast,
  output logic        m_tvalid,
  input  wire         m_tready,
  output logic [7:0]  m_tdata    // [2:0] verdict, [3] overflow, zero pad
);

  pptc_pkg::cmd_t     cmd;
  pptc_pkg::status_t  sts;
  pptc_pkg::verdict_t verdict;
  logic               ovf, res_load;

  pptc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(s_tvalid), .in_ready(s_tready),
    .res_load(res_load), .res_free(!m_tvalid || m_tready), .sts(sts), .cmd(cmd)
  );

  pptc_dp #(.DEPTH(DEPTH), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .sts(sts),
    .in_cmd(s_tdata[0]), .in_value(s_tdata[16:1]), .in_last(s_tlast),
    .res_verdict(verdict), .res_overflow(ovf)
  );

  always_ff @(posedge clk) begin
    if (rst) m_tvalid <= 1'b0;
    else if (res_load) m_tvalid <= 1'b1;
    else if (m_tready) m_tvalid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (res_load) m_tdata <= {4'b0, ovf, verdict};
  end

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    res_load |-> (!m_tvalid || m_tready)) else $error("result overwritten");
  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (u_dp.res_verdict == pptc_pkg::VERDICT_NOT_SURE))
    else $error("flags not cleared");
  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.load, cmd.linear_op, cmd.up_step, cmd.dn_step, cmd.hole_write}))
    else $error("overlapping commands");

endmodule
`default_nettype wire

// ===== sv/pptc_ctrl.sv =====
// ----------------------------------------------------------------------------
// pptc_ctrl
// Sequencer: linear containers in one step, heap sift as a read/compare loop.
// ----------------------------------------------------------------------------
`default_nettype none
module pptc_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  output logic                res_load,
  input  wire                 res_free,
  input  pptc_pkg::status_t   sts,
  output pptc_pkg::cmd_t      cmd
);

  pptc_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= pptc_pkg::ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      pptc_pkg::ST_IDLE:    if (in_valid) state_next = pptc_pkg::ST_LINEAR;
      pptc_pkg::ST_LINEAR: begin
        if (sts.heap_push)     state_next = pptc_pkg::ST_UP_RD;
        else if (sts.heap_pop) state_next = pptc_pkg::ST_DN_RD_LAST;
        else                   state_next = pptc_pkg::ST_DONE;
      end
      pptc_pkg::ST_UP_RD:   state_next = sts.up_done ? pptc_pkg::ST_WRITE
                                                     : pptc_pkg::ST_UP_CMP;
      pptc_pkg::ST_UP_CMP:  state_next = sts.up_stop ? pptc_pkg::ST_WRITE
                                                     : pptc_pkg::ST_UP_RD;
      pptc_pkg::ST_DN_RD_LAST: state_next = pptc_pkg::ST_DN_RD_L;
      pptc_pkg::ST_DN_RD_L: begin
        if (sts.dn_no_child)  state_next = pptc_pkg::ST_WRITE;
        else if (sts.dn_has_r) state_next = pptc_pkg::ST_DN_RD_R;
        else                   state_next = pptc_pkg::ST_DN_CMP;
      end
      pptc_pkg::ST_DN_RD_R: state_next = pptc_pkg::ST_DN_CMP;
      pptc_pkg::ST_DN_CMP:  state_next = sts.dn_stop ? pptc_pkg::ST_WRITE
                                                     : pptc_pkg::ST_DN_RD_L;
      pptc_pkg::ST_WRITE:   state_next = pptc_pkg::ST_DONE;
      pptc_pkg::ST_DONE:    if (!sts.last || res_free) state_next = pptc_pkg::ST_IDLE;
      default:              state_next = pptc_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    in_ready = 1'b0;
    res_load = 1'b0;
    unique case (state)
      pptc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      pptc_pkg::ST_LINEAR: begin
        cmd.linear_op = 1'b1;
        cmd.up_start  = sts.heap_push;
        cmd.dn_start  = sts.heap_pop;
      end
      pptc_pkg::ST_UP_RD:      cmd.up_rd = 1'b1;
      pptc_pkg::ST_UP_CMP:     cmd.up_step = 1'b1;
      pptc_pkg::ST_DN_RD_LAST: cmd.dn_rd_l = 1'b0;
      pptc_pkg::ST_DN_RD_L:    cmd.dn_rd_l = 1'b1;
      pptc_pkg::ST_DN_RD_R:    cmd.dn_rd_r = 1'b1;
      pptc_pkg::ST_DN_CMP:     cmd.dn_step = 1'b1;
      pptc_pkg::ST_WRITE:      cmd.hole_write = 1'b1;
      pptc_pkg::ST_DONE: begin
        if (!sts.last || res_free) begin
          cmd.finish = sts.last;
          res_load   = sts.last;
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/pptc_dp.sv =====
// ----------------------------------------------------------------------------
// pptc_dp
// Container stores, counters, failure flags and the heap sift datapath.
// ----------------------------------------------------------------------------
`default_nettype none
module pptc_dp #(
  parameter int unsigned DEPTH      = 1024,
  parameter int unsigned VALUE_BITS = 16
) (
  input  wire                          clk,
  input  wire                          rst,
  input  pptc_pkg::cmd_t               cmd,
  output pptc_pkg::status_t            sts,
  input  wire                          in_cmd,
  input  wire [15:0]                   in_value,
  input  wire                          in_last,
  output pptc_pkg::verdict_t           res_verdict,
  output logic                         res_overflow
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned VB = (VALUE_BITS < 16) ? VALUE_BITS : 16;
  localparam logic [CW-1:0] DepthC = CW'(DEPTH);
  localparam logic [AW-1:0] LastA = AW'(DEPTH - 1);

  logic [VB-1:0] lifo_mem [DEPTH];
  logic [VB-1:0] fifo_mem [DEPTH];
  logic [VB-1:0] heap_mem [DEPTH];

  logic          op_pop, op_last;
  logic [VB-1:0] op_val;
  logic [CW-1:0] lifo_count, fifo_count, heap_count;
  logic [AW-1:0] fifo_head;
  logic          lifo_failed, fifo_failed, heap_failed, overflow_seen;
  logic [VB-1:0] lifo_top, fifo_front, heap_top;

  // heap sift registers
  logic [CW-1:0] hole;       // current hole index
  logic [CW-1:0] hcnt;       // heap size during sift
  logic [VB-1:0] held;       // value travelling with the hole
  logic [VB-1:0] rd_data;
  logic [VB-1:0] left_val;
  logic [CW-1:0] child;
  logic          heap_pop_r; // moved value still to be latched
  logic [VB-1:0] dn_big;     // larger child value

  logic [CW:0]   lchild_w;
  logic [CW-1:0] parent_w;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  assign lchild_w = {hole, 1'b1};
  assign parent_w = (hole - CW'(1)) >> 1;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_pop  <= in_cmd;
      op_val  <= in_value[VB-1:0];
      op_last <= in_last;
    end
  end

  // registered head reads; addresses are stable while an item waits
  always_ff @(posedge clk) begin
    lifo_top   <= lifo_mem[AW'(lifo_count - CW'(1))];
    fifo_front <= fifo_mem[fifo_head];
    heap_top   <= heap_mem[0];
  end

  always_comb begin
    rd_en   = 1'b1;
    rd_addr = '0;
    if (cmd.up_rd)        rd_addr = parent_w[AW-1:0];
    else if (cmd.dn_rd_r) rd_addr = AW'(lchild_w + (CW+1)'(1));
    else if (cmd.dn_rd_l) rd_addr = lchild_w[AW-1:0];
    else                  rd_addr = hcnt[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data <= heap_mem[rd_addr];
  end

  logic lin_push_l, lin_push_f, lin_push_h;
  assign lin_push_l = cmd.linear_op && !op_pop && !lifo_failed && lifo_count < DepthC;
  assign lin_push_f = cmd.linear_op && !op_pop && !fifo_failed && fifo_count < DepthC;
  assign lin_push_h = cmd.linear_op && !op_pop && !heap_failed && heap_count < DepthC;

  logic [AW-1:0] fifo_slot;
  always_comb begin
    logic [AW:0] s;
    s = {1'b0, fifo_head} + (AW+1)'(fifo_count[AW-1:0]);
    if (s >= (AW+1)'(DEPTH)) s = s - (AW+1)'(DEPTH);
    fifo_slot = s[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (lin_push_l) lifo_mem[lifo_count[AW-1:0]] <= op_val;
    if (lin_push_f) fifo_mem[fifo_slot] <= op_val;
    if (cmd.up_step && !sts.up_stop) heap_mem[hole[AW-1:0]] <= rd_data;
    else if (cmd.dn_step && !sts.dn_stop) heap_mem[hole[AW-1:0]] <= dn_big;
    else if (cmd.hole_write) heap_mem[hole[AW-1:0]] <= held;
  end

  // sift status
  logic dn_sel_r;
  assign sts.heap_push   = lin_push_h;
  assign sts.heap_pop    = cmd.linear_op && op_pop && !heap_failed && heap_count != '0
                           && heap_top == op_val && heap_count != CW'(1);
  assign sts.up_done     = hole == '0;
  assign sts.up_stop     = rd_data >= held;
  assign sts.dn_no_child = lchild_w >= {1'b0, hcnt};
  assign sts.dn_has_r    = lchild_w + (CW+1)'(1) < {1'b0, hcnt};
  // even child index means both children were read: rd_data right, left_val left
  assign dn_sel_r        = (child[0] == 1'b0) && rd_data > left_val;
  assign dn_big          = (child[0] == 1'b0 && !dn_sel_r) ? left_val : rd_data;
  assign sts.dn_stop     = dn_big <= held;
  assign sts.last        = op_last;

  always_ff @(posedge clk) begin
    if (rst)               heap_pop_r <= 1'b0;
    else if (cmd.dn_start) heap_pop_r <= 1'b1;
    else if (cmd.dn_rd_l)  heap_pop_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.up_start) begin
      hole <= heap_count;
      held <= op_val;
    end else if (cmd.dn_start) begin
      hole <= '0;
      hcnt <= heap_count - CW'(1);
    end
    if (cmd.dn_rd_l && heap_pop_r) held <= rd_data;
    if (cmd.up_step && !sts.up_stop) hole <= parent_w;
    if (cmd.dn_rd_l) begin
      child <= lchild_w[CW-1:0];
    end
    if (cmd.dn_rd_r) begin
      left_val <= rd_data;
      child    <= CW'(lchild_w + (CW+1)'(1));
    end
    if (cmd.dn_step) begin
      if (!sts.dn_stop) hole <= dn_sel_r ? child : CW'(child - {{(CW-1){1'b0}}, !child[0]});
    end
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      lifo_count <= '0; fifo_count <= '0; heap_count <= '0; fifo_head <= '0;
      lifo_failed <= 1'b0; fifo_failed <= 1'b0; heap_failed <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (cmd.linear_op) begin
      if (!op_pop) begin
        if (lin_push_l) lifo_count <= lifo_count + CW'(1);
        if (lin_push_f) fifo_count <= fifo_count + CW'(1);
        if (lin_push_h) heap_count <= heap_count + CW'(1);
        if ((!lifo_failed && !lin_push_l) || (!fifo_failed && !lin_push_f) ||
            (!heap_failed && !lin_push_h)) overflow_seen <= 1'b1;
      end else begin
        if (!lifo_failed) begin
          if (lifo_count == '0 || lifo_top != op_val) lifo_failed <= 1'b1;
          else lifo_count <= lifo_count - CW'(1);
        end
        if (!fifo_failed) begin
          if (fifo_count == '0 || fifo_front != op_val) fifo_failed <= 1'b1;
          else begin
            fifo_head  <= (fifo_head == LastA) ? '0 : fifo_head + AW'(1);
            fifo_count <= fifo_count - CW'(1);
          end
        end
        if (!heap_failed) begin
          if (heap_count == '0 || heap_top != op_val) heap_failed <= 1'b1;
          else heap_count <= heap_count - CW'(1);
        end
      end
    end
  end

  always_comb begin
    unique case ({lifo_failed, fifo_failed, heap_failed})
      3'b111:  res_verdict = pptc_pkg::VERDICT_IMPOSSIBLE;
      3'b011:  res_verdict = pptc_pkg::VERDICT_STACK;
      3'b101:  res_verdict = pptc_pkg::VERDICT_QUEUE;
      3'b110:  res_verdict = pptc_pkg::VERDICT_PRIORITY;
      default: res_verdict = pptc_pkg::VERDICT_NOT_SURE;
    endcase
  end
  assign res_overflow = overflow_seen;

endmodule
`default_nettype wire
